// ----- design/blr_pkg.sv -----
// ---------------------------------------------------------------------------
// blr_pkg: shared types and constants of the line rasterizer
// Coordinate, delta and error widths, command and register codes, and the
// queue entry that travels from the command front end to the line walker.
// ---------------------------------------------------------------------------
package blr_pkg;

   localparam int COORD_BITS      = 16;
   localparam int DELTA_BITS      = COORD_BITS + 1;
   localparam int ERR_BITS        = COORD_BITS + 2;
   localparam int BYTES_PER_PIXEL = 3;
   localparam int WIDTH_BITS      = 11;
   localparam int HEIGHT_BITS     = 10;
   localparam int OFFSET_BITS     = 23;
   localparam int COLOR_BITS      = 8;
   localparam int PROD_BITS       = WIDTH_BITS + HEIGHT_BITS;
   localparam int CMP_BITS        = (COORD_BITS > WIDTH_BITS) ? COORD_BITS : WIDTH_BITS;
   localparam int Q_DEPTH         = 4;
   localparam int Q_PTR_BITS      = $clog2(Q_DEPTH);
   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;

   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_STEP = 1'b1
   } cmd_type;

   // register select, taken from address bit 2
   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_sel_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [DELTA_BITS-1:0]        delta_type;
   typedef logic signed [ERR_BITS-1:0]   err_type;
   typedef logic [COLOR_BITS-1:0]        chan_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } color_type;

   typedef struct packed {
      cmd_type   cmd;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      delta_type delta_x;
      delta_type delta_y;
      logic      x_neg;
      logic      y_neg;
      err_type   err;
      color_type color;
   } line_cmd_type;

   typedef struct packed {
      logic         valid;
      line_cmd_type entry;
   } queue_head_type;

endpackage

// ----- design/blr_req_if.sv -----
// ---------------------------------------------------------------------------
// blr_req_if: request channel of the line rasterizer
// Valid/ready handshake with load and step command payload.
// ---------------------------------------------------------------------------
interface blr_req_if;
   logic                valid;
   logic                ready;
   logic                command;
   blr_pkg::coord_type  start_x;
   blr_pkg::coord_type  start_y;
   blr_pkg::coord_type  end_x;
   blr_pkg::coord_type  end_y;
   blr_pkg::chan_type   red_in;
   blr_pkg::chan_type   green_in;
   blr_pkg::chan_type   blue_in;

   modport source (
      output valid, command, start_x, start_y, end_x, end_y, red_in, green_in, blue_in,
      input  ready
   );
   modport sink (
      input  valid, command, start_x, start_y, end_x, end_y, red_in, green_in, blue_in,
      output ready
   );
endinterface

// ----- design/blr_rsp_if.sv -----
// ---------------------------------------------------------------------------
// blr_rsp_if: pixel channel of the line rasterizer
// Valid/ready handshake carrying one rasterized pixel per transfer.
// ---------------------------------------------------------------------------
interface blr_rsp_if;
   logic                               valid;
   logic                               ready;
   blr_pkg::coord_type                 pixel_x;
   blr_pkg::coord_type                 pixel_y;
   logic                               visible;
   logic [blr_pkg::OFFSET_BITS-1:0]    byte_offset;
   blr_pkg::chan_type                  red_out;
   blr_pkg::chan_type                  green_out;
   blr_pkg::chan_type                  blue_out;
   logic                               last;

   modport source (
      output valid, pixel_x, pixel_y, visible, byte_offset, red_out, green_out, blue_out, last,
      input  ready
   );
   modport sink (
      input  valid, pixel_x, pixel_y, visible, byte_offset, red_out, green_out, blue_out, last,
      output ready
   );
endinterface

// ----- design/blr_front.sv -----
// ---------------------------------------------------------------------------
// blr_front: command front end
// Accepts requests, classifies load and step, and precomputes the Bresenham
// setup (deltas, directions, initial error) for loads before queueing them.
// ---------------------------------------------------------------------------
module blr_front (
   blr_req_if.sink                    req,
   input  logic                       q_full,
   output logic                       push_valid,
   output blr_pkg::line_cmd_type      push_entry
);

   logic signed [blr_pkg::DELTA_BITS-1:0] diff_x;
   logic signed [blr_pkg::DELTA_BITS-1:0] diff_y;
   blr_pkg::delta_type                    abs_x;
   blr_pkg::delta_type                    abs_y;

   assign req.ready  = !q_full;
   assign push_valid = req.valid && !q_full;

   always_comb begin
      diff_x = {req.end_x[blr_pkg::COORD_BITS-1], req.end_x}
             - {req.start_x[blr_pkg::COORD_BITS-1], req.start_x};
      diff_y = {req.end_y[blr_pkg::COORD_BITS-1], req.end_y}
             - {req.start_y[blr_pkg::COORD_BITS-1], req.start_y};
      abs_x  = diff_x[blr_pkg::DELTA_BITS-1] ? blr_pkg::delta_type'(-diff_x)
                                             : blr_pkg::delta_type'(diff_x);
      abs_y  = diff_y[blr_pkg::DELTA_BITS-1] ? blr_pkg::delta_type'(-diff_y)
                                             : blr_pkg::delta_type'(diff_y);

      push_entry.cmd         = (req.command == 1'b1) ? blr_pkg::CMD_STEP : blr_pkg::CMD_LOAD;
      push_entry.start_x     = req.start_x;
      push_entry.start_y     = req.start_y;
      push_entry.end_x       = req.end_x;
      push_entry.end_y       = req.end_y;
      push_entry.delta_x     = abs_x;
      push_entry.delta_y     = abs_y;
      // walk toward smaller coordinates unless the end lies strictly above
      push_entry.x_neg       = diff_x[blr_pkg::DELTA_BITS-1] || (diff_x == '0);
      push_entry.y_neg       = diff_y[blr_pkg::DELTA_BITS-1] || (diff_y == '0);
      push_entry.err         = $signed({1'b0, abs_x}) - $signed({1'b0, abs_y});
      push_entry.color.red   = req.red_in;
      push_entry.color.green = req.green_in;
      push_entry.color.blue  = req.blue_in;
   end

endmodule

// ----- design/blr_queue.sv -----
// ---------------------------------------------------------------------------
// blr_queue: command queue
// Small register FIFO between the front end and the line walker.
// ---------------------------------------------------------------------------
module blr_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  blr_pkg::line_cmd_type      push_entry,
   output logic                       full,
   input  logic                       pop,
   output blr_pkg::queue_head_type    head
);

   blr_pkg::line_cmd_type               entries_ff [blr_pkg::Q_DEPTH];
   logic [blr_pkg::Q_PTR_BITS-1:0]      wr_ptr_ff;
   logic [blr_pkg::Q_PTR_BITS-1:0]      wr_ptr_in;
   logic [blr_pkg::Q_PTR_BITS-1:0]      rd_ptr_ff;
   logic [blr_pkg::Q_PTR_BITS-1:0]      rd_ptr_in;
   logic [blr_pkg::Q_PTR_BITS:0]        count_ff;
   logic [blr_pkg::Q_PTR_BITS:0]        count_in;
   logic                                do_pop;

   assign full       = (count_ff == (blr_pkg::Q_PTR_BITS+1)'(blr_pkg::Q_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = entries_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- design/blr_back.sv -----
// ---------------------------------------------------------------------------
// blr_back: line walker and pixel addressing
// Holds the Bresenham state, steps one pixel per queued step command, and
// forms visibility and the framebuffer byte offset over two register stages.
// ---------------------------------------------------------------------------
module blr_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [blr_pkg::WIDTH_BITS-1:0]     screen_width,
   input  logic [blr_pkg::HEIGHT_BITS-1:0]    screen_height,
   input  blr_pkg::queue_head_type            head,
   output logic                               pop,
   blr_rsp_if.source                          rsp
);

   // walker state
   logic                   active_ff,  active_in;
   blr_pkg::coord_type     cur_x_ff,   cur_x_in;
   blr_pkg::coord_type     cur_y_ff,   cur_y_in;
   blr_pkg::coord_type     tgt_x_ff,   tgt_x_in;
   blr_pkg::coord_type     tgt_y_ff,   tgt_y_in;
   blr_pkg::delta_type     dx_ff,      dx_in;
   blr_pkg::delta_type     dy_ff,      dy_in;
   logic                   x_neg_ff,   x_neg_in;
   logic                   y_neg_ff,   y_neg_in;
   blr_pkg::err_type       err_ff,     err_in;
   blr_pkg::color_type     color_ff,   color_in;

   // first pixel stage
   logic                                  s1_valid_ff;
   blr_pkg::coord_type                    s1_x_ff;
   blr_pkg::coord_type                    s1_y_ff;
   logic                                  s1_visible_ff;
   logic                                  s1_last_ff;
   logic [blr_pkg::PROD_BITS-1:0]         s1_prod_ff;
   logic [blr_pkg::WIDTH_BITS-1:0]        s1_col_ff;
   blr_pkg::color_type                    s1_color_ff;

   // output stage
   logic                                  out_valid_ff;
   blr_pkg::coord_type                    out_x_ff;
   blr_pkg::coord_type                    out_y_ff;
   logic                                  out_visible_ff;
   logic [blr_pkg::OFFSET_BITS-1:0]       out_offset_ff;
   blr_pkg::color_type                    out_color_ff;
   logic                                  out_last_ff;

   logic                                  s2_free;
   logic                                  s1_free;
   logic                                  is_load;
   logic                                  emit;
   logic                                  is_last;
   logic                                  visible;
   logic [blr_pkg::HEIGHT_BITS-1:0]       row;
   logic [blr_pkg::PROD_BITS-1:0]         row_ext;
   logic [blr_pkg::PROD_BITS-1:0]         width_ext;
   logic [blr_pkg::PROD_BITS-1:0]         prod;
   logic [blr_pkg::OFFSET_BITS-1:0]       pix_index;
   logic signed [blr_pkg::ERR_BITS:0]     e2;
   logic signed [blr_pkg::ERR_BITS:0]     dx_ext;
   logic signed [blr_pkg::ERR_BITS:0]     dy_ext;
   logic signed [blr_pkg::ERR_BITS:0]     err_sum;
   logic                                  move_x;
   logic                                  move_y;

   assign s2_free = !out_valid_ff || rsp.ready;
   assign s1_free = !s1_valid_ff || s2_free;
   assign is_load = (head.entry.cmd == blr_pkg::CMD_LOAD);
   // loads and idle steps never wait on the pixel pipe
   assign pop     = head.valid && (is_load || !active_ff || s1_free);
   assign emit    = pop && !is_load && active_ff;

   always_comb begin
      is_last = (cur_x_ff == tgt_x_ff) && (cur_y_ff == tgt_y_ff);
      visible = !cur_x_ff[blr_pkg::COORD_BITS-1] && !cur_y_ff[blr_pkg::COORD_BITS-1]
             && (blr_pkg::CMP_BITS'($unsigned(cur_x_ff)) < blr_pkg::CMP_BITS'(screen_width))
             && (blr_pkg::CMP_BITS'($unsigned(cur_y_ff)) < blr_pkg::CMP_BITS'(screen_height));
      row       = blr_pkg::HEIGHT_BITS'(blr_pkg::CMP_BITS'($unsigned(cur_y_ff)));
      row_ext   = blr_pkg::PROD_BITS'(row);
      width_ext = blr_pkg::PROD_BITS'(screen_width);
      prod      = row_ext * width_ext;

      e2      = {err_ff, 1'b0};
      dx_ext  = $signed({2'b00, dx_ff});
      dy_ext  = $signed({2'b00, dy_ff});
      move_x  = (e2 > -dy_ext);
      move_y  = (e2 < dx_ext);
      err_sum = {err_ff[blr_pkg::ERR_BITS-1], err_ff};
      if (move_x) begin
         err_sum = err_sum - dy_ext;
      end
      if (move_y) begin
         err_sum = err_sum + dx_ext;
      end

      active_in = active_ff;
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      tgt_x_in  = tgt_x_ff;
      tgt_y_in  = tgt_y_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      x_neg_in  = x_neg_ff;
      y_neg_in  = y_neg_ff;
      err_in    = err_ff;
      color_in  = color_ff;

      if (pop && is_load) begin
         active_in = 1'b1;
         cur_x_in  = head.entry.start_x;
         cur_y_in  = head.entry.start_y;
         tgt_x_in  = head.entry.end_x;
         tgt_y_in  = head.entry.end_y;
         dx_in     = head.entry.delta_x;
         dy_in     = head.entry.delta_y;
         x_neg_in  = head.entry.x_neg;
         y_neg_in  = head.entry.y_neg;
         err_in    = head.entry.err;
         color_in  = head.entry.color;
      end else if (emit) begin
         if (is_last) begin
            active_in = 1'b0;
         end else begin
            err_in = err_sum[blr_pkg::ERR_BITS-1:0];
            if (move_x) begin
               cur_x_in = x_neg_ff ? cur_x_ff - blr_pkg::COORD_BITS'(1)
                                   : cur_x_ff + blr_pkg::COORD_BITS'(1);
            end
            if (move_y) begin
               cur_y_in = y_neg_ff ? cur_y_ff - blr_pkg::COORD_BITS'(1)
                                   : cur_y_ff + blr_pkg::COORD_BITS'(1);
            end
         end
      end

      pix_index = blr_pkg::OFFSET_BITS'(s1_prod_ff) + blr_pkg::OFFSET_BITS'(s1_col_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         tgt_x_ff  <= '0;
         tgt_y_ff  <= '0;
         dx_ff     <= '0;
         dy_ff     <= '0;
         x_neg_ff  <= 1'b0;
         y_neg_ff  <= 1'b0;
         err_ff    <= '0;
         color_ff  <= '0;
      end else begin
         active_ff <= active_in;
         cur_x_ff  <= cur_x_in;
         cur_y_ff  <= cur_y_in;
         tgt_x_ff  <= tgt_x_in;
         tgt_y_ff  <= tgt_y_in;
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         x_neg_ff  <= x_neg_in;
         y_neg_ff  <= y_neg_in;
         err_ff    <= err_in;
         color_ff  <= color_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= emit;
         end
         if (s2_free) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         s1_x_ff       <= cur_x_ff;
         s1_y_ff       <= cur_y_ff;
         s1_visible_ff <= visible;
         s1_last_ff    <= is_last;
         s1_prod_ff    <= visible ? prod : '0;
         s1_col_ff     <= visible ? blr_pkg::WIDTH_BITS'(blr_pkg::CMP_BITS'($unsigned(cur_x_ff)))
                                  : '0;
         s1_color_ff   <= color_ff;
      end
      if (s2_free && s1_valid_ff) begin
         out_x_ff       <= s1_x_ff;
         out_y_ff       <= s1_y_ff;
         out_visible_ff <= s1_visible_ff;
         out_offset_ff  <= blr_pkg::OFFSET_BITS'(pix_index * blr_pkg::BYTES_PER_PIXEL);
         out_color_ff   <= s1_color_ff;
         out_last_ff    <= s1_last_ff;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.pixel_x     = out_x_ff;
   assign rsp.pixel_y     = out_y_ff;
   assign rsp.visible     = out_visible_ff;
   assign rsp.byte_offset = out_offset_ff;
   assign rsp.red_out     = out_color_ff.red;
   assign rsp.green_out   = out_color_ff.green;
   assign rsp.blue_out    = out_color_ff.blue;
   assign rsp.last        = out_last_ff;

endmodule

// ----- design/bresenham_line_rasterizer_top.sv -----
// ---------------------------------------------------------------------------
// bresenham_line_rasterizer_top: Bresenham line rasterizer
// Walks a loaded line one pixel per step request, flags pixels inside the
// screen and gives their byte offset in a 3-byte-per-pixel framebuffer.
//
//   channel    direction  handshake              payload
//   req_chan   in         valid/ready            command, endpoints, color
//   rsp_chan   out        valid/ready            pixel, visible, offset, color, last
//   APB port   in         psel/penable, pready   screen_width, screen_height
//
// One request per cycle is taken while the queue is not full; a step with a line
// active yields one pixel through the queue, the first pixel stage and the offset stage.
// The walker's combinational error update sets the rate of one pixel per cycle while rsp_chan does not stall.
// Synchronous reset clears the queue, the walker and the pipe, and sets the
// screen to 640 x 480. A stalled rsp_chan fills the pipe and then the
// four-entry queue before req_chan.ready drops.
// ---------------------------------------------------------------------------
module bresenham_line_rasterizer_top (
   input  logic                                  clock,
   input  logic                                  reset,
   blr_req_if.sink                               req_chan,
   blr_rsp_if.source                             rsp_chan,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [blr_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [blr_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic [blr_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                  pready
);

   logic [blr_pkg::WIDTH_BITS-1:0]   width_ff;
   logic [blr_pkg::HEIGHT_BITS-1:0]  height_ff;
   blr_pkg::reg_sel_type             reg_sel;
   logic                             csr_write;
   logic                             q_full;
   logic                             push_valid;
   blr_pkg::line_cmd_type            push_entry;
   logic                             pop;
   blr_pkg::queue_head_type          head;

   assign pready    = 1'b1;
   assign reg_sel   = blr_pkg::reg_sel_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= blr_pkg::WIDTH_RESET;
         height_ff <= blr_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         case (reg_sel)
            blr_pkg::REG_WIDTH:  width_ff  <= pwdata[blr_pkg::WIDTH_BITS-1:0];
            blr_pkg::REG_HEIGHT: height_ff <= pwdata[blr_pkg::HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         blr_pkg::REG_WIDTH:  prdata = blr_pkg::CSR_DATA_BITS'(width_ff);
         blr_pkg::REG_HEIGHT: prdata = blr_pkg::CSR_DATA_BITS'(height_ff);
         default:             prdata = '0;
      endcase
   end

   blr_front u_front (
      .req        (req_chan),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   blr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head       (head)
   );

   blr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .head          (head),
      .pop           (pop),
      .rsp           (rsp_chan)
   );

endmodule

// ----- sim/blr_tb_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blr_tb_pkg: request and pixel records plus the pixel scoreboard
// The scoreboard walks its own copy of each loaded line, queues the pixel
// every step request should produce and compares what the block emits.
// ---------------------------------------------------------------------------
package blr_tb_pkg;

   typedef struct {
      blr_pkg::cmd_type   command;
      blr_pkg::coord_type start_x;
      blr_pkg::coord_type start_y;
      blr_pkg::coord_type end_x;
      blr_pkg::coord_type end_y;
      blr_pkg::chan_type  red;
      blr_pkg::chan_type  green;
      blr_pkg::chan_type  blue;
   } line_request_type;

   typedef struct {
      blr_pkg::coord_type               pixel_x;
      blr_pkg::coord_type               pixel_y;
      logic                             visible;
      logic [blr_pkg::OFFSET_BITS-1:0]  byte_offset;
      blr_pkg::chan_type                red;
      blr_pkg::chan_type                green;
      blr_pkg::chan_type                blue;
      logic                             last;
   } pixel_type;

   class pixel_scoreboard;
      logic [blr_pkg::WIDTH_BITS-1:0]  screen_width;
      logic [blr_pkg::HEIGHT_BITS-1:0] screen_height;
      bit                 walking;
      blr_pkg::coord_type cur_x;
      blr_pkg::coord_type cur_y;
      blr_pkg::coord_type target_x;
      blr_pkg::coord_type target_y;
      blr_pkg::delta_type delta_x;
      blr_pkg::delta_type delta_y;
      bit                 x_neg;
      bit                 y_neg;
      int                 error_acc;
      blr_pkg::color_type color;
      pixel_type          expected_pixels[$];
      int                 errors;
      int                 requests;
      int                 loads;
      int                 pixels_checked;
      int                 hidden_pixels;

      function new();
         screen_width  = blr_pkg::WIDTH_RESET;
         screen_height = blr_pkg::HEIGHT_RESET;
         walking   = 1'b0;
         cur_x     = '0;
         cur_y     = '0;
         target_x  = '0;
         target_y  = '0;
         delta_x   = '0;
         delta_y   = '0;
         x_neg     = 1'b0;
         y_neg     = 1'b0;
         error_acc = 0;
         color     = '0;
         errors    = 0;
         requests  = 0;
         loads     = 0;
         pixels_checked = 0;
         hidden_pixels  = 0;
      endfunction

      function void write_reg(blr_pkg::reg_sel_type sel, logic [31:0] value);
         case (sel)
            blr_pkg::REG_WIDTH:  screen_width  = value[blr_pkg::WIDTH_BITS-1:0];
            blr_pkg::REG_HEIGHT: screen_height = value[blr_pkg::HEIGHT_BITS-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      // pixel at the current position, then advance one Bresenham step
      function pixel_type next_pixel();
         pixel_type   p;
         int          cx;
         int          cy;
         int          w;
         int          h;
         int          e2;
         logic [31:0] off;
         cx = cur_x;
         cy = cur_y;
         w  = int'(screen_width);
         h  = int'(screen_height);
         p.pixel_x = cur_x;
         p.pixel_y = cur_y;
         p.visible = (cx >= 0) && (cy >= 0) && (cx < w) && (cy < h);
         off = p.visible ? (cy * w * blr_pkg::BYTES_PER_PIXEL + cx * blr_pkg::BYTES_PER_PIXEL)
                         : 32'd0;
         p.byte_offset = off[blr_pkg::OFFSET_BITS-1:0];
         p.red   = color.red;
         p.green = color.green;
         p.blue  = color.blue;
         p.last  = (cur_x == target_x) && (cur_y == target_y);
         if (p.last) begin
            walking = 1'b0;
         end else begin
            e2 = 2 * error_acc;
            if (e2 > -int'(delta_y)) begin
               error_acc -= int'(delta_y);
               cur_x = blr_pkg::coord_type'(cx + (x_neg ? -1 : 1));
            end
            if (e2 < int'(delta_x)) begin
               error_acc += int'(delta_x);
               cur_y = blr_pkg::coord_type'(cy + (y_neg ? -1 : 1));
            end
         end
         return p;
      endfunction

      function void note_request(line_request_type rq);
         int sx;
         int sy;
         int ex;
         int ey;
         requests++;
         if (rq.command == blr_pkg::CMD_LOAD) begin
            loads++;
            sx = rq.start_x;
            sy = rq.start_y;
            ex = rq.end_x;
            ey = rq.end_y;
            cur_x     = rq.start_x;
            cur_y     = rq.start_y;
            target_x  = rq.end_x;
            target_y  = rq.end_y;
            delta_x   = blr_pkg::delta_type'((ex >= sx) ? ex - sx : sx - ex);
            delta_y   = blr_pkg::delta_type'((ey >= sy) ? ey - sy : sy - ey);
            x_neg     = !(sx < ex);
            y_neg     = !(sy < ey);
            error_acc = int'(delta_x) - int'(delta_y);
            color     = {rq.red, rq.green, rq.blue};
            walking   = 1'b1;
         end else if (walking) begin
            expected_pixels.push_back(next_pixel());
         end
      endfunction

      function void mismatch(string field, logic signed [31:0] want, logic signed [31:0] got);
         errors++;
         $error("pixel %0d: %s expected %0d, got %0d", pixels_checked, field, want, got);
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            errors++;
            $error("pixel at (%0d,%0d) arrived with none outstanding", got.pixel_x, got.pixel_y);
            return;
         end
         want = expected_pixels.pop_front();
         if (got.pixel_x !== want.pixel_x) mismatch("pixel_x", want.pixel_x, got.pixel_x);
         if (got.pixel_y !== want.pixel_y) mismatch("pixel_y", want.pixel_y, got.pixel_y);
         if (got.visible !== want.visible) mismatch("visible", want.visible, got.visible);
         if (got.byte_offset !== want.byte_offset)
            mismatch("byte_offset", want.byte_offset, got.byte_offset);
         if (got.red !== want.red) mismatch("red_out", want.red, got.red);
         if (got.green !== want.green) mismatch("green_out", want.green, got.green);
         if (got.blue !== want.blue) mismatch("blue_out", want.blue, got.blue);
         if (got.last !== want.last) mismatch("last", want.last, got.last);
         if (!want.visible) hidden_pixels++;
         pixels_checked++;
      endfunction
   endclass

endpackage

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: line rasterizer testbench
// Loads lines and steps through them with random request gaps and pixel-side
// backpressure, across several screen sizes, and checks every emitted pixel.
// ---------------------------------------------------------------------------
module tb;

   localparam int IDLE_LIMIT = 2000;

   logic                              clock;
   logic                              reset;
   logic                              psel;
   logic                              penable;
   logic                              pwrite;
   logic [blr_pkg::CSR_ADDR_BITS-1:0] paddr;
   logic [blr_pkg::CSR_DATA_BITS-1:0] pwdata;
   logic [blr_pkg::CSR_DATA_BITS-1:0] prdata;
   logic                              pready;

   blr_req_if req_chan();
   blr_rsp_if rsp_chan();

   bresenham_line_rasterizer_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   blr_tb_pkg::pixel_scoreboard  sb = new();
   int                           useful_items = 0;
   int                           calm_left = 0;
   int                           screens = 1;
   blr_tb_pkg::pixel_type        seen_pixel;
   blr_tb_pkg::line_request_type seen_req;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      reset = 1'b1;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
   end

   function automatic int gap_length(bit zero_ok);
      int r;
      r = $urandom_range(0, 99);
      if (zero_ok && r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 80);
   endfunction

   // sink pacing: bursts of ready, short stalls, a few long ones
   initial begin
      int run;
      int hold;
      rsp_chan.ready = 1'b0;
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 16);
         @(negedge clock) rsp_chan.ready <= 1'b1;
         repeat (run - 1) @(negedge clock);
         hold = gap_length(1'b0);
         @(negedge clock) rsp_chan.ready <= 1'b0;
         repeat (hold - 1) @(negedge clock);
      end
   end

   // check pixels first, then note the request taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_pixel.pixel_x     = rsp_chan.pixel_x;
            seen_pixel.pixel_y     = rsp_chan.pixel_y;
            seen_pixel.visible     = rsp_chan.visible;
            seen_pixel.byte_offset = rsp_chan.byte_offset;
            seen_pixel.red         = rsp_chan.red_out;
            seen_pixel.green       = rsp_chan.green_out;
            seen_pixel.blue        = rsp_chan.blue_out;
            seen_pixel.last        = rsp_chan.last;
            sb.check_pixel(seen_pixel);
         end
         if (req_chan.valid && req_chan.ready) begin
            seen_req.command = blr_pkg::cmd_type'(req_chan.command);
            seen_req.start_x = req_chan.start_x;
            seen_req.start_y = req_chan.start_y;
            seen_req.end_x   = req_chan.end_x;
            seen_req.end_y   = req_chan.end_y;
            seen_req.red     = req_chan.red_in;
            seen_req.green   = req_chan.green_in;
            seen_req.blue    = req_chan.blue_in;
            sb.note_request(seen_req);
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $error("no handshake for %0d cycles, %0d pixels outstanding", IDLE_LIMIT, sb.pending());
      $display("tb: done, errors");
      $finish;
   end

   function automatic blr_tb_pkg::line_request_type rand_request(blr_pkg::cmd_type cmd);
      blr_tb_pkg::line_request_type rq;
      rq.command = cmd;
      rq.start_x = blr_pkg::coord_type'($urandom);
      rq.start_y = blr_pkg::coord_type'($urandom);
      rq.end_x   = blr_pkg::coord_type'($urandom);
      rq.end_y   = blr_pkg::coord_type'($urandom);
      rq.red     = blr_pkg::chan_type'($urandom);
      rq.green   = blr_pkg::chan_type'($urandom);
      rq.blue    = blr_pkg::chan_type'($urandom);
      return rq;
   endfunction

   task automatic send_request(blr_tb_pkg::line_request_type rq);
      int gap;
      @(negedge clock);
      if (rq.command == blr_pkg::CMD_LOAD || sb.walking) useful_items++;
      req_chan.command  <= rq.command;
      req_chan.start_x  <= rq.start_x;
      req_chan.start_y  <= rq.start_y;
      req_chan.end_x    <= rq.end_x;
      req_chan.end_y    <= rq.end_y;
      req_chan.red_in   <= rq.red;
      req_chan.green_in <= rq.green;
      req_chan.blue_in  <= rq.blue;
      req_chan.valid    <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 60);
         gap = gap_length(1'b1);
      end
      if (gap > 0) begin
         @(negedge clock) req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic step_line(int count);
      repeat (count) send_request(rand_request(blr_pkg::CMD_STEP));
   endtask

   task automatic draw_line(int sx, int sy, int ex, int ey, blr_pkg::color_type c, int steps);
      blr_tb_pkg::line_request_type rq;
      rq = rand_request(blr_pkg::CMD_LOAD);
      rq.start_x = blr_pkg::coord_type'(sx);
      rq.start_y = blr_pkg::coord_type'(sy);
      rq.end_x   = blr_pkg::coord_type'(ex);
      rq.end_y   = blr_pkg::coord_type'(ey);
      rq.red     = c.red;
      rq.green   = c.green;
      rq.blue    = c.blue;
      send_request(rq);
      step_line(steps);
   endtask

   // drop valid, drain all pixels, then let queued loads and idle steps clear the queue
   task automatic wait_quiet();
      @(negedge clock) req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(blr_pkg::reg_sel_type sel, logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= value;
      @(negedge clock) penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_reg(sel, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // upper bits are random: only the register's own width should matter
   task automatic set_screen(int w, int h);
      wait_quiet();
      write_csr(blr_pkg::REG_WIDTH, ($urandom & ~32'h7FF) | (w & 32'h7FF));
      write_csr(blr_pkg::REG_HEIGHT, ($urandom & ~32'h3FF) | (h & 32'h3FF));
      screens++;
   endtask

   task automatic draw_phase(int budget);
      int target;
      int r;
      int w;
      int h;
      int sx;
      int sy;
      int ex;
      int ey;
      int span;
      int adx;
      int ady;
      int steps;
      target = useful_items + budget;
      while (useful_items < target) begin
         r = $urandom_range(0, 99);
         w = sb.screen_width;
         h = sb.screen_height;
         if (r < 78) begin
            // short line around the screen so edges and corners get crossed
            sx = int'($urandom_range(0, w + 16)) - 8;
            sy = int'($urandom_range(0, h + 16)) - 8;
            r = $urandom_range(0, 99);
            span = (r < 85) ? 12 : ((r < 98) ? 60 : 400);
            ex = sx + int'($urandom_range(0, 2 * span)) - span;
            ey = sy + int'($urandom_range(0, 2 * span)) - span;
            r = $urandom_range(0, 99);
            if (r < 12) ey = sy;
            else if (r < 24) ex = sx;
            else if (r < 32) ey = sy + (ex - sx);
            else if (r < 38) ey = sy - (ex - sx);
            else if (r < 42) begin
               ex = sx;
               ey = sy;
            end
            adx = (ex >= sx) ? ex - sx : sx - ex;
            ady = (ey >= sy) ? ey - sy : sy - ey;
            steps = ((adx > ady) ? adx : ady) + 1;
            r = $urandom_range(0, 99);
            if (r < 10) steps = $urandom_range(1, steps);
            else if (r < 20) steps += $urandom_range(1, 3);
            draw_line(sx, sy, ex, ey, blr_pkg::color_type'($urandom), steps);
         end else if (r < 90) begin
            // full-range endpoints, walk a few pixels, next load replaces it
            send_request(rand_request(blr_pkg::CMD_LOAD));
            step_line($urandom_range(1, 8));
         end else begin
            repeat ($urandom_range(1, 4))
               send_request(rand_request(blr_pkg::cmd_type'($urandom_range(0, 1))));
         end
      end
   endtask

   initial begin
      req_chan.valid    = 1'b0;
      req_chan.command  = blr_pkg::CMD_LOAD;
      req_chan.start_x  = '0;
      req_chan.start_y  = '0;
      req_chan.end_x    = '0;
      req_chan.end_y    = '0;
      req_chan.red_in   = '0;
      req_chan.green_in = '0;
      req_chan.blue_in  = '0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      while (reset) @(posedge clock);

      // directed: idle step, single point, extreme endpoints, screen edges
      step_line(1);
      draw_line(7, 7, 7, 7, {8'hFF, 8'h00, 8'hFF}, 2);
      draw_line(-32768, -32768, 32767, 32767, {8'h00, 8'hFF, 8'h00}, 2);
      draw_line(32767, 32767, -32768, -32768, {8'hFF, 8'hFF, 8'hFF}, 2);
      draw_line(-1, -1, 1, 1, {8'h00, 8'h00, 8'h00}, 3);
      draw_line(637, 479, 640, 478, {8'h80, 8'h01, 8'h7F}, 4);
      draw_line(1, 3, -1, 0, {8'h55, 8'hAA, 8'h0F}, 5);

      draw_phase(200);
      set_screen(1, 1);
      draw_phase(100);
      set_screen(1900, 1000);
      draw_phase(150);
      set_screen(0, 1000);
      draw_phase(60);
      set_screen(1900, 0);
      draw_phase(40);
      set_screen(2047, 1023);
      draw_phase(100);
      set_screen($urandom_range(1, 1900), $urandom_range(1, 1000));
      draw_phase(150);

      wait_quiet();
      repeat (10) @(posedge clock);
      $display("tb: %0d requests (%0d loads), %0d pixels checked, %0d of them off screen",
               sb.requests, sb.loads, sb.pixels_checked, sb.hidden_pixels);
      $display("tb: %0d screen sizes, zero and out-of-range sizes among them", screens);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

// ----- sim.f -----
design/blr_pkg.sv
design/blr_req_if.sv
design/blr_rsp_if.sv
design/blr_front.sv
design/blr_queue.sv
design/blr_back.sv
design/bresenham_line_rasterizer_top.sv
sim/blr_tb_pkg.sv
sim/tb.sv
